### hw/rtl/fpa_pkg.sv
// Shared types and constants for the fixed-point ALU.
// Holds the opcode codes, the divider geometry and the pipeline stage struct.
// No dependencies.
package fpa_pkg;

  // Number of fractional bits in the fixed-point format.
  localparam int FRAC_BITS = 8;

  // The scaled dividend magnitude is |a| shifted left by FRAC_BITS.
  localparam int DVD_W = 32 + FRAC_BITS;

  // The divider retires one quotient bit per stage.
  localparam int DIV_STEPS = DVD_W;

  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_MUL = 4'd2,
    OP_DIV = 4'd3,
    OP_INC = 4'd4,
    OP_DEC = 4'd5,
    OP_EQ  = 4'd6,
    OP_NE  = 4'd7,
    OP_GE  = 4'd8,
    OP_GT  = 4'd9,
    OP_LE  = 4'd10,
    OP_LT  = 4'd11,
    OP_MIN = 4'd12,
    OP_MAX = 4'd13
  } op_t;

  // Payload that travels down the divider chain next to its valid bit.
  typedef struct packed {
    logic               is_div;  // divide with a nonzero divisor
    logic               neg;     // quotient must be negated
    logic [31:0]        val;     // result for every other operation
    logic               cmp;
    logic               dz;
    logic [31:0]        rem;     // partial remainder
    logic [DVD_W-1:0]   dvd;     // dividend bits not yet consumed
    logic [31:0]        dsr;     // divisor magnitude
    logic [31:0]        quo;     // low quotient bits collected so far
  } pipe_t;

endpackage

### hw/rtl/fpa_div_stage.sv
// One registered step of the restoring divider.
// Depends on fpa_pkg for the pipe_t stage struct.
module fpa_div_stage
  import fpa_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  input  pipe_t in_data,
  output logic  out_valid,
  output pipe_t out_data
);

  logic [32:0] trial;
  logic        fits;
  logic [32:0] diff;
  pipe_t       step;

  // Bring down one dividend bit and subtract the divisor if it fits.
  always_comb begin
    trial = {in_data.rem, in_data.dvd[DVD_W-1]};
    fits  = (trial >= {1'b0, in_data.dsr});
    diff  = trial - {1'b0, in_data.dsr};
    step      = in_data;
    step.rem  = fits ? diff[31:0] : trial[31:0];
    step.dvd  = {in_data.dvd[DVD_W-2:0], 1'b0};
    step.quo  = {in_data.quo[30:0], fits};
  end

  // Valid bit is reset; payload is not.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_data <= step;
  end

endmodule

### hw/rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
// Depends on fpa_pkg and fpa_div_stage.
// Path: input register, operation stage, product select stage, the divider
// chain (one quotient bit per stage) and the result registers.
// Throughput: one transfer per cycle for every opcode; busy stays low.
// Results appear for one cycle with done high; the receiver cannot stall.
// Synchronous reset clears all valid bits; no results are in flight after it.
module fixed_point_alu
  import fpa_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [3:0]         opcode,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] value_out,
  output logic               compare_true,
  output logic               divide_by_zero
);

  // Input register stage.
  logic               in_valid;
  logic [3:0]         in_op;
  logic signed [31:0] in_a;
  logic signed [31:0] in_b;

  // Operation stage: simple results, product and divider setup.
  logic               op_valid;
  logic               op_is_mul;
  logic signed [63:0] op_prod;
  pipe_t              op_data;
  pipe_t              op_next;

  // Product select stage, head of the divider chain.
  logic               head_valid;
  pipe_t              head_data;
  pipe_t              head_next;

  logic               chain_valid [DIV_STEPS+1];
  pipe_t              chain_data  [DIV_STEPS+1];

  logic [31:0]        mag_a;
  logic [31:0]        mag_b;
  logic               lt;

  assign busy = 1'b0;

  // Capture each transfer.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start;
    end
    in_op <= opcode;
    in_a  <= operand_a;
    in_b  <= operand_b;
  end

  // Compute all results but the product and the quotient, and prepare the divider.
  always_comb begin
    mag_a = in_a[31] ? (32'd0 - in_a) : in_a;
    mag_b = in_b[31] ? (32'd0 - in_b) : in_b;
    lt    = (in_a < in_b);
    op_next        = '0;
    op_next.dvd    = {mag_a, {FRAC_BITS{1'b0}}};
    op_next.dsr    = mag_b;
    op_next.neg    = in_a[31] ^ in_b[31];
    case (in_op)
      OP_ADD: op_next.val = in_a + in_b;
      OP_SUB: op_next.val = in_a - in_b;
      OP_DIV: begin
        if (in_b == 32'sd0) begin
          op_next.val = in_a;
          op_next.dz  = 1'b1;
        end else begin
          op_next.is_div = 1'b1;
        end
      end
      OP_INC: op_next.val = in_a + 32'sd1;
      OP_DEC: op_next.val = in_a - 32'sd1;
      OP_EQ:  op_next.cmp = (in_a == in_b);
      OP_NE:  op_next.cmp = (in_a != in_b);
      OP_GE:  op_next.cmp = !lt;
      OP_GT:  op_next.cmp = (in_a > in_b);
      OP_LE:  op_next.cmp = (in_a <= in_b);
      OP_LT:  op_next.cmp = lt;
      OP_MIN: op_next.val = lt ? in_a : in_b;
      OP_MAX: op_next.val = lt ? in_b : in_a;
      default: op_next.val = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
    end else begin
      op_valid <= in_valid;
    end
    op_data   <= op_next;
    op_is_mul <= (in_op == OP_MUL);
    op_prod   <= in_a * in_b;
  end

  // Scale the product back to the fixed-point format.
  always_comb begin
    head_next = op_data;
    if (op_is_mul) begin
      head_next.val = op_prod[FRAC_BITS+31:FRAC_BITS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= op_valid;
    end
    head_data <= head_next;
  end

  assign chain_valid[0] = head_valid;
  assign chain_data[0]  = head_data;

  // Divider chain, one quotient bit per stage.
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    fpa_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[i]),
      .in_data   (chain_data[i]),
      .out_valid (chain_valid[i+1]),
      .out_data  (chain_data[i+1])
    );
  end

  // Apply the quotient sign and drive the result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= chain_valid[DIV_STEPS];
    end
    if (chain_data[DIV_STEPS].is_div) begin
      value_out <= chain_data[DIV_STEPS].neg ? (32'd0 - chain_data[DIV_STEPS].quo)
                                             : chain_data[DIV_STEPS].quo;
    end else begin
      value_out <= chain_data[DIV_STEPS].val;
    end
    compare_true   <= chain_data[DIV_STEPS].cmp;
    divide_by_zero <= chain_data[DIV_STEPS].dz;
  end

  // A result never flags both a comparison and a divide by zero.
  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    done |-> !(compare_true && divide_by_zero))
    else $error("compare and divide-by-zero flags both set");

  // A comparison result carries a zero value.
  a_cmp_zero_value: assert property (@(posedge clk) disable iff (rst)
    (done && compare_true) |-> (value_out == 32'sd0))
    else $error("comparison result with nonzero value");

  // No result follows directly after reset.
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

  // The block never stalls the sender.
  a_never_busy: assert property (@(posedge clk)
    !busy)
    else $error("busy raised");

endmodule
